FILE: src/lmcr_pkg.sv
// lmcr_pkg: shared types, command codes and constants for the led matrix chain refresher
// no dependencies; imported by lmcr_frame and led_matrix_chain_refresher

package lmcr_pkg;

   // default number of driver chips in the chain
   localparam int CHAIN_LENGTH_DEF = 4;

   // geometry of the pixel store
   localparam int NUM_ROWS  = 8;
   localparam int ROW_W     = 3;
   localparam int BYTE_W    = 8;
   localparam int WORD_W    = 16;
   localparam int COL_W     = 5;
   localparam logic [ROW_W-1:0] LAST_ROW = 3'd7;

   // settings registers
   localparam int NUM_REGS = 5;
   localparam int REG_IDX_W = 3;
   localparam logic [REG_IDX_W-1:0] REG_DISPLAY_TEST  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_SCAN_LIMIT    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_DECODE_MODE   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_INTENSITY     = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_SHUTDOWN_MODE = 3'd4;
   localparam logic [REG_IDX_W-1:0] LAST_SET          = REG_SHUTDOWN_MODE;

   // chip register addresses, in settings order
   localparam logic [BYTE_W-1:0] ADDR_DISPLAY_TEST  = 8'h0F;
   localparam logic [BYTE_W-1:0] ADDR_SCAN_LIMIT    = 8'h0B;
   localparam logic [BYTE_W-1:0] ADDR_DECODE_MODE   = 8'h09;
   localparam logic [BYTE_W-1:0] ADDR_INTENSITY     = 8'h0A;
   localparam logic [BYTE_W-1:0] ADDR_SHUTDOWN_MODE = 8'h0C;

   // reset values of the settings registers
   localparam logic [BYTE_W-1:0] CFG_RESET [NUM_REGS] = '{8'd0, 8'd7, 8'd0, 8'd1, 8'd1};

   // command codes
   typedef enum logic [2:0] {
      FN_SET_PIXEL   = 3'd0,
      FN_SET_REFRESH = 3'd1,
      FN_REFRESH     = 3'd2,
      FN_CLEAR       = 3'd3,
      FN_INIT        = 3'd4
   } lmcr_func_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETTINGS,
      ST_LOAD,
      ST_REFRESH
   } lmcr_state_type;

   // write/clear request into the pixel store
   typedef struct packed {
      logic             en;
      logic             clear;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             value;
   } lmcr_wr_type;

endpackage

FILE: src/lmcr_frame.sv
// lmcr_frame: 8-row pixel store, one bit per column of the chain
// depends on lmcr_pkg (lmcr_wr_type, NUM_ROWS, ROW_W)

module lmcr_frame #(
   parameter int ROW_BITS = 8 * lmcr_pkg::CHAIN_LENGTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lmcr_pkg::lmcr_wr_type         wr,
   input  logic [lmcr_pkg::ROW_W-1:0]    rd_row,
   output logic [ROW_BITS-1:0]           rd_data
);
   import lmcr_pkg::*;

   logic [ROW_BITS-1:0] store_ff [NUM_ROWS];
   logic [ROW_BITS-1:0] mask;

   // one-hot column mask for the pixel write
   always_comb begin
      for (int i = 0; i < ROW_BITS; i++) begin
         mask[i] = (wr.col == COL_W'(i));
      end
   end

   // store update: clear wins, then single-pixel write
   always_ff @(posedge clock) begin
      if (reset || wr.clear) begin
         for (int r = 0; r < NUM_ROWS; r++) begin
            store_ff[r] <= '0;
         end
      end else if (wr.en) begin
         if (wr.value) begin
            store_ff[wr.row] <= store_ff[wr.row] | mask;
         end else begin
            store_ff[wr.row] <= store_ff[wr.row] & ~mask;
         end
      end
   end

   assign rd_data = store_ff[rd_row];

endmodule

FILE: src/led_matrix_chain_refresher.sv
// led_matrix_chain_refresher: command sequencer and serial word generator for a
// chain of 8x8 led driver chips; depends on lmcr_pkg and lmcr_frame
//
//   channel  ports                                  direction  use
//   req      req_valid/req_stall, func, pos, value  in         one command per item
//   rsp      rsp_valid/rsp_stall, word, latch, last out        one chain word per item
//   csr      csr_wr_en, csr_index, csr_wdata        in         settings register writes
//
// A refresh first loads the first row into the digit shifter, then emits one word per
// cycle while the output is not stalled, as the row shifter hands out one byte per chip.
// Initialise first emits the settings words, one per chip for each of the 5 registers.
// Reset is synchronous; it clears the pixel store and loads the settings defaults.
// A stalled output holds its word and the sequencer waits; a new command is taken
// while the final word of the previous one still waits in the output register.

module led_matrix_chain_refresher #(
   parameter int CHAIN_LENGTH = lmcr_pkg::CHAIN_LENGTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // command channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [2:0]                        req_func,
   input  logic [3:0]                        req_pos_row,
   input  logic [5:0]                        req_pos_col,
   input  logic                              req_pixel_value,
   // word channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [lmcr_pkg::WORD_W-1:0]       rsp_word,
   output logic                              rsp_latch,
   output logic                              rsp_last,
   // settings write port
   input  logic                              csr_wr_en,
   input  logic [lmcr_pkg::REG_IDX_W-1:0]    csr_index,
   input  logic [lmcr_pkg::BYTE_W-1:0]       csr_wdata
);
   import lmcr_pkg::*;

   localparam int ROW_BITS = BYTE_W * CHAIN_LENGTH;
   localparam int CHIP_W   = (CHAIN_LENGTH > 1) ? $clog2(CHAIN_LENGTH) : 1;
   localparam int CFG_SH_W = NUM_REGS * WORD_W;
   localparam logic [CHIP_W-1:0] LAST_CHIP = CHIP_W'(CHAIN_LENGTH - 1);

   lmcr_state_type state_ff, state_in;

   logic [BYTE_W-1:0]   cfg_ff [NUM_REGS];
   logic [CFG_SH_W-1:0] cfg_sh_ff;
   logic [ROW_BITS-1:0] row_sh_ff;
   logic [CHIP_W-1:0]   chip_ff;
   logic [ROW_W-1:0]    row_ff;
   logic [REG_IDX_W-1:0] set_ff;

   logic                rsp_valid_ff;
   logic [WORD_W-1:0]   rsp_word_ff;
   logic                rsp_latch_ff;
   logic                rsp_last_ff;

   logic                req_accept;
   logic                rsp_accept;
   logic                out_free;
   logic                emit;
   logic                chip_last;
   logic [WORD_W-1:0]   word_in;
   logic                latch_in;
   logic                last_in;
   lmcr_func_type       func;
   logic                pix_ok;
   lmcr_wr_type         wr;
   logic [ROW_W-1:0]    rd_row;
   logic [ROW_BITS-1:0] rd_data;

   assign func       = lmcr_func_type'(req_func);
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign chip_last  = (chip_ff == LAST_CHIP);

   // settings registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            cfg_ff[i] <= CFG_RESET[i];
         end
      end else if (csr_wr_en) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            if (csr_index == REG_IDX_W'(i)) begin
               cfg_ff[i] <= csr_wdata;
            end
         end
      end
   end

   // pixel write and clear requests, taken with the command
   assign pix_ok = (req_pos_row >= 4'd1) && (req_pos_row <= 4'(NUM_ROWS)) &&
                   (req_pos_col >= 6'd1) && (req_pos_col <= 6'(ROW_BITS));

   always_comb begin
      wr.en    = req_accept && pix_ok &&
                 (func == FN_SET_PIXEL || func == FN_SET_REFRESH);
      wr.clear = req_accept && (func == FN_CLEAR || func == FN_INIT);
      wr.row   = ROW_W'(req_pos_row - 4'd1);
      wr.col   = COL_W'(req_pos_col - 6'd1);
      wr.value = req_pixel_value;
   end

   // during a refresh the next row is fetched for the row's last word
   assign rd_row = (state_ff == ST_REFRESH) ? ROW_W'(row_ff + 1'b1) : row_ff;

   lmcr_frame #(
      .ROW_BITS (ROW_BITS)
   ) u_frame (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_row  (rd_row),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (func)
                  FN_SET_REFRESH, FN_REFRESH, FN_CLEAR: state_in = ST_LOAD;
                  FN_INIT:                              state_in = ST_SETTINGS;
                  default:                              state_in = ST_IDLE;
               endcase
            end
         end
         ST_SETTINGS: begin
            if (emit && chip_last && set_ff == LAST_SET) state_in = ST_LOAD;
         end
         ST_LOAD: state_in = ST_REFRESH;
         ST_REFRESH: begin
            if (emit && chip_last && row_ff == LAST_ROW) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: handshake and the word to emit
   always_comb begin
      req_stall = 1'b1;
      emit      = 1'b0;
      word_in   = '0;
      latch_in  = 1'b0;
      last_in   = 1'b0;
      case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_SETTINGS: begin
            emit     = out_free;
            word_in  = cfg_sh_ff[CFG_SH_W-1 -: WORD_W];
            latch_in = chip_last;
         end
         ST_LOAD: ;
         ST_REFRESH: begin
            emit     = out_free;
            word_in  = {BYTE_W'(row_ff) + 8'd1, row_sh_ff[ROW_BITS-1 -: BYTE_W]};
            latch_in = chip_last;
            last_in  = chip_last && (row_ff == LAST_ROW);
         end
         default: ;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // counters
   always_ff @(posedge clock) begin
      if (reset) begin
         chip_ff <= '0;
         row_ff  <= '0;
         set_ff  <= '0;
      end else if (req_accept) begin
         chip_ff <= '0;
         row_ff  <= '0;
         set_ff  <= '0;
      end else if (emit) begin
         chip_ff <= chip_last ? '0 : CHIP_W'(chip_ff + 1'b1);
         if (chip_last && state_ff == ST_REFRESH)  row_ff <= row_ff + 1'b1;
         if (chip_last && state_ff == ST_SETTINGS) set_ff <= set_ff + 1'b1;
      end
   end

   // settings digit shifter: one address/data pair per chain group
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cfg_sh_ff <= {ADDR_DISPLAY_TEST,  cfg_ff[REG_DISPLAY_TEST],
                       ADDR_SCAN_LIMIT,    cfg_ff[REG_SCAN_LIMIT],
                       ADDR_DECODE_MODE,   cfg_ff[REG_DECODE_MODE],
                       ADDR_INTENSITY,     cfg_ff[REG_INTENSITY],
                       ADDR_SHUTDOWN_MODE, cfg_ff[REG_SHUTDOWN_MODE]};
      end else if (emit && chip_last && state_ff == ST_SETTINGS) begin
         cfg_sh_ff <= cfg_sh_ff << WORD_W;
      end
   end

   // row digit shifter: farthest chip's byte at the top
   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD) begin
         row_sh_ff <= rd_data;
      end else if (emit && state_ff == ST_REFRESH) begin
         row_sh_ff <= chip_last ? rd_data : (row_sh_ff << BYTE_W);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_accept) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_word_ff  <= word_in;
         rsp_latch_ff <= latch_in;
         rsp_last_ff  <= last_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign rsp_latch = rsp_latch_ff;
   assign rsp_last  = rsp_last_ff;

`ifndef SYNTHESIS
   // the closing word of a command always ends a chain group
   a_last_latch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_latch_ff)
      else $error("last word without latch");

   // settings phase hands over to the refresh after the final group
   a_settings_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SETTINGS && emit && chip_last && set_ff == LAST_SET
      |=> state_ff == ST_LOAD)
      else $error("settings phase did not end");

   // a row load starts a refresh on the farthest chip
   a_load_start: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |=> state_ff == ST_REFRESH && chip_ff == '0)
      else $error("refresh did not start on first chip");
`endif

endmodule
